### rtl/pps_pkg.sv
// Shared types, widths and codes for the preemptive priority scheduler.
package pps_pkg;

  localparam int MAX_JOBS_DEF = 16;

  localparam int ARR_W    = 16;
  localparam int BUR_W    = 16;
  localparam int PRI_W    = 8;
  localparam int TIME_W   = 20;
  localparam int JOB_ID_W = 5;
  localparam int KIND_W   = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // in_tdata: arrival, burst, priority from bit 0 up
  localparam int IN_DATA_W  = 40;
  // out_tdata: 69 bits of fields, padded to 9 bytes
  localparam int OUT_DATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_SERVE = 2'd2,
    ST_RESP  = 2'd3
  } state_t;

  // Best job seen so far as it travels along the chain
  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] prio;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [BUR_W-1:0] remaining;
  } cand_t;

  // Command broadcast to every cell; the addressed cell acts on it
  typedef struct packed {
    logic             load;
    logic             dec;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
  } cell_cmd_t;

endpackage

### rtl/pps_cell.sv
// One job slot: holds a job and compares it with the candidate from its left neighbour.
module pps_cell #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pps_pkg::cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]           sel_idx,
  input  logic [CNT_W-1:0]           job_count,
  input  logic [pps_pkg::TIME_W-1:0] now,
  input  pps_pkg::cand_t             cand_in,
  input  logic [IDX_W-1:0]           idx_in,
  output pps_pkg::cand_t             cand_out,
  output logic [IDX_W-1:0]           idx_out
);

  logic [pps_pkg::ARR_W-1:0] arr_r;
  logic [pps_pkg::BUR_W-1:0] bur_r;
  logic [pps_pkg::PRI_W-1:0] pri_r;
  logic [pps_pkg::BUR_W-1:0] rem_r;

  pps_pkg::cand_t    cand_r, cand_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic here;
  logic elig;
  logic take;

  assign here = (sel_idx == IDX_W'(INDEX));

  always_comb begin
    elig = (CNT_W'(INDEX) < job_count) &&
           ({{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, arr_r} <= now) &&
           (rem_r != '0);
    // left neighbour has the lower id, so it keeps full ties
    take = elig && (!cand_in.found || (pri_r < cand_in.prio) ||
                    ((pri_r == cand_in.prio) && (arr_r < cand_in.arrival)));
    if (take) begin
      cand_nxt = '{found: 1'b1, prio: pri_r, arrival: arr_r,
                   burst: bur_r, remaining: rem_r};
      idx_nxt  = IDX_W'(INDEX);
    end else begin
      cand_nxt = cand_in;
      idx_nxt  = idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && here) begin
      arr_r <= cmd.arrival;
      bur_r <= cmd.burst;
      pri_r <= cmd.prio;
      rem_r <= cmd.burst;
    end else if (cmd.dec && here) begin
      rem_r <= rem_r - pps_pkg::BUR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      idx_r  <= '0;
    end else begin
      cand_r <= cand_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign cand_out = cand_r;
  assign idx_out  = idx_r;

endmodule

### rtl/pps_chain.sv
// Row of job cells; the winning candidate leaves the far end.
module pps_chain #(
  parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pps_pkg::cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]           sel_idx,
  input  logic [CNT_W-1:0]           job_count,
  input  logic [pps_pkg::TIME_W-1:0] now,
  output pps_pkg::cand_t             best,
  output logic [IDX_W-1:0]           best_idx
);

  pps_pkg::cand_t   cand [MAX_JOBS+1];
  logic [IDX_W-1:0] idx  [MAX_JOBS+1];

  assign cand[0] = '0;
  assign idx[0]  = '0;

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    pps_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel_idx   (sel_idx),
      .job_count (job_count),
      .now       (now),
      .cand_in   (cand[g]),
      .idx_in    (idx[g]),
      .cand_out  (cand[g+1]),
      .idx_out   (idx[g+1])
    );
  end

  assign best     = cand[MAX_JOBS];
  assign best_idx = idx[MAX_JOBS];

endmodule

### rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: control, time keeping and result register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: kind; tdata: arrival, burst, priority
//  out_    | out | out_tvalid / out_tready| tdata: one result per input transaction
//
// Flow: a tick passes through scan, serve and response while the selection wave crosses
//   the row of MAX_JOBS job cells one cell per cycle; clear, load and no-op go straight to response.
// One transaction at a time; the next is taken while a result still waits at the output.
// Reset (rst_n low, synchronous) empties the table and zeroes time; no clearing pass.
// A stalled output holds its result; one more transaction is taken and worked, then its
//   result waits for the output and the input stays stalled until the output frees.
module preemptive_priority_scheduler #(
  parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] arrival, [31:16] burst, [39:32] priority
  input  logic [pps_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [pps_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [4:0] ran_job, [24:5] tick_end, [25] same_segment, [26] job_finished,
  // [46:27] turnaround, [66:47] waiting, [67] all_done, [68] table_full, [71:69] zero
  output logic [pps_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int TW    = pps_pkg::TIME_W;

  // ---------------------------------------------------------------- state
  pps_pkg::state_t   state_r, state_nxt;
  logic [IDX_W-1:0]  scan_cnt_r;
  logic [CNT_W-1:0]  job_count_r;
  logic [CNT_W-1:0]  done_count_r;
  logic [TW-1:0]     now_r;
  logic [CNT_W-1:0]  last_served_r;

  // result being assembled
  logic [CNT_W-1:0]          res_ran_r;
  logic                      res_same_r;
  logic                      res_fin_r;
  logic                      res_full_r;
  logic [TW-1:0]             res_tat_r;
  logic [pps_pkg::BUR_W-1:0] res_bur_r;

  // output register
  logic                            out_valid_r;
  logic [pps_pkg::OUT_DATA_W-1:0]  out_data_r;

  // ---------------------------------------------------------------- decode
  pps_pkg::kind_t            kind;
  logic [pps_pkg::ARR_W-1:0] in_arr;
  logic [pps_pkg::BUR_W-1:0] in_bur;
  logic [pps_pkg::PRI_W-1:0] in_pri;
  logic                      in_acc;
  logic                      tbl_full;
  logic                      load_ok;

  assign kind     = pps_pkg::kind_t'(in_tuser);
  assign in_arr   = in_tdata[15:0];
  assign in_bur   = in_tdata[31:16];
  assign in_pri   = in_tdata[39:32];
  assign in_acc   = in_tvalid && in_tready;
  assign tbl_full = (job_count_r == CNT_W'(MAX_JOBS));
  assign load_ok  = (kind == pps_pkg::KIND_LOAD) && (in_bur != '0) && !tbl_full;

  // ---------------------------------------------------------------- cell row
  pps_pkg::cell_cmd_t cmd;
  logic [IDX_W-1:0]   sel_idx;
  pps_pkg::cand_t     best;
  logic [IDX_W-1:0]   best_idx;

  pps_chain #(
    .MAX_JOBS (MAX_JOBS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sel_idx   (sel_idx),
    .job_count (job_count_r),
    .now       (now_r),
    .best      (best),
    .best_idx  (best_idx)
  );

  // ---------------------------------------------------------------- serve maths
  logic [TW-1:0]    now_inc;
  logic [CNT_W-1:0] ran_id;
  logic             fin;
  logic [TW-1:0]    tat;
  logic [TW-1:0]    bur_ext;
  logic [TW-1:0]    wt;
  logic             out_free;

  assign now_inc  = (now_r == pps_pkg::TIME_MAX) ? now_r : now_r + TW'(1);
  assign ran_id   = CNT_W'(best_idx) + CNT_W'(1);
  assign fin      = best.found && (best.remaining == pps_pkg::BUR_W'(1));
  assign tat      = now_inc - {{(TW-pps_pkg::ARR_W){1'b0}}, best.arrival};
  assign bur_ext  = {{(TW-pps_pkg::BUR_W){1'b0}}, res_bur_r};
  // negative waiting only arises once time has saturated
  assign wt       = (res_fin_r && (res_tat_r >= bur_ext)) ? res_tat_r - bur_ext : '0;
  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (kind == pps_pkg::KIND_TICK) ? pps_pkg::ST_SCAN : pps_pkg::ST_RESP;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (scan_cnt_r == IDX_W'(MAX_JOBS - 1)) begin
          state_nxt = pps_pkg::ST_SERVE;
        end
      end
      pps_pkg::ST_SERVE: state_nxt = pps_pkg::ST_RESP;
      pps_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pps_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.arrival = in_arr;
    cmd.burst   = in_bur;
    cmd.prio    = in_pri;
    sel_idx     = job_count_r[IDX_W-1:0];
    case (state_r)
      pps_pkg::ST_IDLE: begin
        // ready is high throughout idle, so valid alone marks the transaction
        in_tready = 1'b1;
        cmd.load  = in_tvalid && load_ok;
      end
      pps_pkg::ST_SERVE: begin
        cmd.dec = best.found;
        sel_idx = best_idx;
      end
      pps_pkg::ST_SCAN, pps_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pps_pkg::ST_IDLE;
      scan_cnt_r    <= '0;
      job_count_r   <= '0;
      done_count_r  <= '0;
      now_r         <= '0;
      last_served_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == pps_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      end else begin
        scan_cnt_r <= '0;
      end

      if (state_r == pps_pkg::ST_IDLE && in_acc) begin
        if (kind == pps_pkg::KIND_CLEAR) begin
          job_count_r   <= '0;
          done_count_r  <= '0;
          now_r         <= '0;
          last_served_r <= '0;
        end else if (load_ok) begin
          job_count_r <= job_count_r + CNT_W'(1);
        end
      end

      if (state_r == pps_pkg::ST_SERVE) begin
        now_r         <= now_inc;
        last_served_r <= best.found ? ran_id : '0;
        if (fin) begin
          done_count_r <= done_count_r + CNT_W'(1);
        end
      end

      if (state_r == pps_pkg::ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result registers
  always_ff @(posedge clk) begin
    if (state_r == pps_pkg::ST_IDLE && in_acc) begin
      res_ran_r  <= '0;
      res_same_r <= 1'b0;
      res_fin_r  <= 1'b0;
      res_tat_r  <= '0;
      res_bur_r  <= '0;
      res_full_r <= (kind == pps_pkg::KIND_LOAD) && (in_bur != '0) && tbl_full;
    end else if (state_r == pps_pkg::ST_SERVE) begin
      res_ran_r  <= best.found ? ran_id : '0;
      res_same_r <= best.found && (last_served_r == ran_id);
      res_fin_r  <= fin;
      res_tat_r  <= fin ? tat : '0;
      res_bur_r  <= best.burst;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pps_pkg::ST_RESP && out_free) begin
      out_data_r <= {3'b000,
                     res_full_r,
                     done_count_r == job_count_r,
                     wt,
                     res_tat_r,
                     res_fin_r,
                     res_same_r,
                     now_r,
                     pps_pkg::JOB_ID_W'(res_ran_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- assertions
  a_done_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_count_r <= job_count_r)
    else $error("more jobs finished than loaded");

  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pps_pkg::ST_SERVE && fin) |=>
      done_count_r == $past(done_count_r) + CNT_W'(1))
    else $error("finished job not counted");

  a_fin_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[26]) |-> (out_tdata[4:0] != '0 || MAX_JOBS > 30))
    else $error("finish reported without a served job");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[66:47] <= out_tdata[46:27]))
    else $error("waiting exceeds turnaround");

  a_scan_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pps_pkg::ST_IDLE && in_acc && kind != pps_pkg::KIND_TICK) |=>
      state_r == pps_pkg::ST_RESP)
    else $error("non-tick transaction entered the scan");

endmodule

### dv/pps_checker.sv
// Scoreboard for the preemptive priority scheduler: watches both channels, predicts and compares.
module pps_checker
  import pps_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrors out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]          pad;
    logic                table_full;
    logic                all_done;
    logic [TIME_W-1:0]   waiting;
    logic [TIME_W-1:0]   turnaround;
    logic                job_finished;
    logic                same_segment;
    logic [TIME_W-1:0]   tick_end;
    logic [JOB_ID_W-1:0] ran_job;
  } sched_res_t;

  logic [ARR_W-1:0] arr_tab [MAX_JOBS];
  logic [BUR_W-1:0] bur_tab [MAX_JOBS];
  logic [PRI_W-1:0] pri_tab [MAX_JOBS];
  logic [BUR_W-1:0] rem_tab [MAX_JOBS];
  int unsigned      n_loaded;
  int unsigned      n_done;
  int unsigned      prev_id;
  logic [TIME_W-1:0] clock_now;

  sched_res_t sched_outcomes [$];
  sched_res_t want;
  sched_res_t got;
  int         fails;

  function automatic sched_res_t schedule_item(kind_t k, logic [ARR_W-1:0] arr,
                                               logic [BUR_W-1:0] bur, logic [PRI_W-1:0] pri);
    sched_res_t  r;
    int          best;
    int          i;
    bit          found;
    int unsigned id;
    r = '0;
    case (k)
      KIND_CLEAR: begin
        n_loaded  = 0;
        n_done    = 0;
        clock_now = '0;
        prev_id   = 0;
      end
      KIND_LOAD: begin
        if (bur != '0) begin
          if (n_loaded >= MAX_JOBS) begin
            r.table_full = 1'b1;
          end else begin
            arr_tab[n_loaded] = arr;
            bur_tab[n_loaded] = bur;
            pri_tab[n_loaded] = pri;
            rem_tab[n_loaded] = bur;
            n_loaded++;
          end
        end
      end
      KIND_TICK: begin
        found = 1'b0;
        best  = 0;
        // strict compares keep the lower id on a full tie
        for (i = 0; i < int'(n_loaded); i++) begin
          if (TIME_W'(arr_tab[i]) > clock_now || rem_tab[i] == '0) continue;
          if (!found || pri_tab[i] < pri_tab[best] ||
              (pri_tab[i] == pri_tab[best] && arr_tab[i] < arr_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (clock_now != TIME_MAX) clock_now++;
        id = 0;
        if (found) begin
          id = best + 1;
          r.ran_job      = id[JOB_ID_W-1:0];
          r.same_segment = (prev_id == id);
          rem_tab[best]  = rem_tab[best] - 1'b1;
          if (rem_tab[best] == '0) begin
            r.job_finished = 1'b1;
            r.turnaround   = clock_now - TIME_W'(arr_tab[best]);
            r.waiting      = (r.turnaround >= TIME_W'(bur_tab[best])) ?
                             r.turnaround - TIME_W'(bur_tab[best]) : '0;
            n_done++;
          end
        end
        prev_id = id;
      end
      default: ;
    endcase
    r.tick_end = clock_now;
    r.all_done = (n_done == n_loaded);
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  initial begin
    fails      = 0;
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      n_loaded  = 0;
      n_done    = 0;
      clock_now = '0;
      prev_id   = 0;
      sched_outcomes.delete();
    end else begin
      // retire first, so a result never matches the transaction taken at the same edge
      if (out_tvalid && out_tready) begin
        got = sched_res_t'(out_tdata);
        if (sched_outcomes.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, expected nothing, got %h", $time, got);
        end else begin
          want = sched_outcomes.pop_front();
          check_field("ran_job",      want.ran_job,      got.ran_job);
          check_field("tick_end",     want.tick_end,     got.tick_end);
          check_field("same_segment", want.same_segment, got.same_segment);
          check_field("job_finished", want.job_finished, got.job_finished);
          check_field("turnaround",   want.turnaround,   got.turnaround);
          check_field("waiting",      want.waiting,      got.waiting);
          check_field("all_done",     want.all_done,     got.all_done);
          check_field("table_full",   want.table_full,   got.table_full);
          check_field("padding",      want.pad,          got.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        sched_outcomes.push_back(schedule_item(kind_t'(in_tuser), in_tdata[15:0],
                                               in_tdata[31:16], in_tdata[39:32]));
      end
    end
    pending    <= sched_outcomes.size();
    fail_count <= fails;
  end

endmodule

### dv/tb_preemptive_priority_scheduler.sv
// Testbench top for the preemptive priority scheduler: stimulus, flow control and verdict.
module tb_preemptive_priority_scheduler;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_JOBS    = MAX_JOBS_DEF;
  // the cycle limit is many times the slowest legal run
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [15:0] arrival, [31:16] burst, [39:32] priority
  logic [KIND_W-1:0]     in_tuser;   // [1:0] kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // ran_job, tick_end, same_segment, job_finished,
                                     // turnaround, waiting, all_done, table_full, pad

  int chk_fails;
  int chk_pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int sched_items;
  bit hold_trig;
  int cycles;

  preemptive_priority_scheduler #(.MAX_JOBS(MAX_JOBS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pps_checker #(.MAX_JOBS(MAX_JOBS)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One transaction on the input side. An optional gap drops tvalid first; back-to-back
  // transactions keep tvalid high, so it sees a single update per time step.
  task automatic send_item(input kind_t k, input logic [ARR_W-1:0] arr,
                           input logic [BUR_W-1:0] bur, input logic [PRI_W-1:0] pri);
    int gap;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {pri, bur, arr};
    do @(posedge clk); while (!in_tready);
    // no-ops and zero-burst loads leave the block untouched; they do not count
    if (k != KIND_NOP && !(k == KIND_LOAD && bur == '0)) sched_items++;
  endtask

  // Sender pauses until every predicted result has been retired.
  // pending is registered, so the loop waits on the clock before each check of it.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off whenever hold_trig flips
  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** preemptive_priority_scheduler: FAILED **");
    $finish;
  end

  initial begin
    int               phase;
    int               phase_end [3];
    int               n_jobs;
    int               n_ticks;
    int               arr_top;
    int               burst_sum;
    int               pick;
    int               j;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;

    phase_end[0] = 500;
    phase_end[1] = 980;
    phase_end[2] = 1450;
    sched_items  = 0;
    hold_trig    = 1'b0;
    snd_idle_pct = 10;
    rcv_idle_pct <= 48;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= KIND_CLEAR;
    rst_n        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    send_item(KIND_TICK, '0, '0, '0);              // idle tick on an empty table
    send_item(KIND_NOP, '1, '1, '1);               // no-op, every data bit high
    send_item(KIND_CLEAR, '1, '1, '1);             // clear ignores its data
    send_item(KIND_LOAD, 16'd0, 16'd0, 8'd0);      // zero burst: dropped, no id used
    send_item(KIND_LOAD, 16'd2, 16'd2, 8'd5);      // id 1
    send_item(KIND_LOAD, 16'd2, 16'd1, 8'd5);      // id 2: ties id 1 on priority and arrival
    send_item(KIND_LOAD, 16'd1, 16'd1, 8'd0);      // id 3: preempts at tick 1
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF); // id 4: never arrives
    send_item(KIND_LOAD, 16'd0, 16'd2, 8'd5);      // id 5: earliest arrival wins the tie
    // 5, 3 (preemption), 5, 1, 1 (same segment), 2, then idle
    repeat (7) send_item(KIND_TICK, '0, '0, '0);
    send_item(KIND_NOP, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0);
    drain_results();

    // ---- random part, three flow-control phases ----
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 10;
          rcv_idle_pct <= 48;
        end
        1: begin
          snd_idle_pct = 48;
          rcv_idle_pct <= 10;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct <= 0;
        end
      endcase

      if (phase == 1) begin
        // long receiver hold-off while the sender keeps pushing; this also overfills the table
        hold_trig <= ~hold_trig;
        send_item(KIND_CLEAR, '0, '0, '0);
        repeat (MAX_JOBS + 4) begin
          send_item(KIND_LOAD, 16'($urandom_range(0, 8)), 16'($urandom_range(1, 4)),
                    8'($urandom_range(0, 3)));
        end
      end

      while (sched_items < phase_end[phase]) begin
        if ($urandom_range(0, 99) < 85) begin
          // well-formed run: clear (usually), load a batch, tick until it should drain
          if ($urandom_range(0, 5) != 0) begin
            send_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
          end
          n_jobs    = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_JOBS - 1, MAX_JOBS + 2)
                                                   : $urandom_range(1, 8);
          burst_sum = 0;
          arr_top   = 0;
          for (j = 0; j < n_jobs; j++) begin
            if ($urandom_range(0, 19) == 0) begin
              // wild job: full-range fields, may be a zero burst or never arrive
              arr = 16'($urandom);
              bur = 16'($urandom);
              pri = 8'($urandom);
            end else begin
              arr = 16'($urandom_range(0, 12));
              bur = 16'($urandom_range(1, 5));
              pri = 8'($urandom_range(0, 3));
              burst_sum += int'(bur);
              if (int'(arr) > arr_top) arr_top = int'(arr);
            end
            send_item(KIND_LOAD, arr, bur, pri);
          end
          n_ticks = burst_sum + arr_top + $urandom_range(0, 4);
          for (j = 0; j < n_ticks; j++) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
              send_item(KIND_NOP, 16'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick == 1) begin
              send_item(KIND_LOAD, 16'($urandom), 16'd0, 8'($urandom));
            end else if (pick == 2) begin
              // late arrival mid-run
              send_item(KIND_LOAD, 16'($urandom_range(0, 40)), 16'($urandom_range(1, 3)),
                        8'($urandom_range(0, 3)));
            end else begin
              send_item(KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
            end
          end
        end else begin
          // noise: any kind, full-range fields
          repeat ($urandom_range(1, 8)) begin
            send_item(kind_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      8'($urandom));
          end
        end
      end
      drain_results();
    end

    // last tick may still be crossing the job row
    repeat (MAX_JOBS + 8) @(posedge clk);
    if (chk_fails == 0) begin
      $display("** preemptive_priority_scheduler: PASSED **");
    end else begin
      $display("** preemptive_priority_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

### preemptive_priority_scheduler.f
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/pps_chain.sv
rtl/preemptive_priority_scheduler.sv
dv/pps_checker.sv
dv/tb_preemptive_priority_scheduler.sv
